### hdl/byte_ring_fifo_with_line_detect_core_assert.svh
// Assertion macros shared by the FIFO modules.
// Each one expects i_clk and i_rst_n in scope.
`ifndef BYTE_RING_FIFO_WITH_LINE_DETECT_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_LINE_DETECT_CORE_ASSERT_SVH

// Same-cycle implication
`define BRFLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BRFLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/brfld_pkg.sv
`default_nettype none

package brfld_pkg;

    // Storage geometry
    localparam int DEPTH     = 256;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W     = $clog2(DEPTH + 1);
    localparam int MAX_BURST = 64;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int LIM_W  = 7;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 6;
    localparam int FILL_W = 9;
    localparam int CMP_W  = (OCC_W > LIM_W) ? OCC_W : LIM_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LINE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE = 8'd10;

    // Controller to datapath
    typedef struct packed {
        logic              load;       // latch the input transaction
        logic              put;        // store byte, emit put result
        logic              emit_none;  // emit a result without a byte
        logic [STAT_W-1:0] none_status;
        logic              clr_flag;   // clear line flag with emit_none
        logic              rd_issue;   // read store at current pointer
        logic              emit_byte;  // emit read data, commit pop/advance
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             occ_zero;
        logic             flag;
        logic             lim_zero;
        logic             byte_done;
        logic             out_free;
    } t_dp_stat;

    // Circular pointer advance
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] ptr);
        logic [ADDR_W-1:0] res;
        if (ptr == ADDR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/brfld_ctrl.sv
`default_nettype none
`include "byte_ring_fifo_with_line_detect_core_assert.svh"

module brfld_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire brfld_pkg::t_dp_stat i_stat,
    output brfld_pkg::t_dp_cmd      o_cmd
);
    import brfld_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = o_s_tready && i_s_tvalid;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_PUT: begin
                        if (i_stat.out_free) begin
                            o_cmd.put = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    CMD_GET: begin
                        if (!i_stat.occ_zero) begin
                            n_state = S_READ;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit_none   = 1'b1;
                            o_cmd.none_status = ST_EMPTY;
                            n_state           = S_IDLE;
                        end
                    end
                    CMD_LINE: begin
                        if (i_stat.flag && !i_stat.lim_zero && !i_stat.occ_zero) begin
                            n_state = S_READ;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit_none   = 1'b1;
                            o_cmd.none_status = i_stat.flag ? ST_OK : ST_EMPTY;
                            o_cmd.clr_flag    = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                    CMD_PEEK: begin
                        if (!i_stat.occ_zero && !i_stat.lim_zero) begin
                            n_state = S_READ;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit_none   = 1'b1;
                            o_cmd.none_status = i_stat.occ_zero ? ST_EMPTY : ST_OK;
                            n_state           = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    n_state         = i_stat.byte_done ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `BRFLD_ASSERT_NEXT(a_accept_exec, w_accept, r_state == S_EXEC, "accept did not start work")
    `BRFLD_ASSERT_NEXT(a_read_emit, r_state == S_READ, r_state == S_EMIT, "read not followed by emit")
    `BRFLD_ASSERT_NEXT(a_emit_hold, (r_state == S_EMIT) && !i_stat.out_free,
                       r_state == S_EMIT, "emit left while output blocked")

endmodule

`default_nettype wire

### hdl/brfld_dp.sv
`default_nettype none
`include "byte_ring_fifo_with_line_detect_core_assert.svh"

module brfld_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [brfld_pkg::CMD_W-1:0]   i_in_cmd,
    input  wire logic [brfld_pkg::BYTE_W-1:0]  i_in_data,
    input  wire logic [brfld_pkg::LIM_W-1:0]   i_in_limit,
    input  wire brfld_pkg::t_dp_cmd            i_cmd,
    output brfld_pkg::t_dp_stat                o_stat,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic                               o_m_tlast,
    output logic [brfld_pkg::BYTE_W-1:0]       o_out_byte,
    output logic                               o_byte_valid,
    output logic [brfld_pkg::STAT_W-1:0]       o_status,
    output logic [brfld_pkg::LEN_W-1:0]        o_line_length,
    output logic [brfld_pkg::FILL_W-1:0]       o_fill_level,
    output logic                               o_line_ready
);
    import brfld_pkg::*;

    // Byte store, no reset
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // FIFO control state
    logic [ADDR_W-1:0] r_wptr, n_wptr;
    logic [ADDR_W-1:0] r_rptr, n_rptr;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_flag, n_flag;

    // Latched transaction and burst progress
    logic [CMD_W-1:0]  r_cmd;
    logic [BYTE_W-1:0] r_data;
    logic [LIM_W-1:0]  r_lim;
    logic [LIM_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_peek_ptr, n_peek_ptr;

    // Output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_last, n_out_last;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_bvalid, n_out_bvalid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic [FILL_W-1:0] r_out_fill, n_out_fill;
    logic              r_out_flag, n_out_flag;

    logic              w_full;
    logic              w_out_free;
    logic              w_done;
    logic [LIM_W-1:0]  w_len_inc;
    logic [LIM_W-1:0]  w_lim_sat;
    logic [LIM_W-1:0]  w_lim_new;
    logic [CMP_W-1:0]  w_lim_cmp;
    logic [CMP_W-1:0]  w_occ_cmp;
    logic              w_pop;

    assign w_full     = (r_occ == OCC_W'(DEPTH));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_len_inc  = r_len + LIM_W'(1);
    assign w_pop      = i_cmd.emit_byte && (r_cmd != CMD_PEEK);

    // Limit for the latched command: line take count or peek count
    assign w_lim_sat = (i_in_limit > LIM_W'(MAX_BURST)) ? LIM_W'(MAX_BURST) : i_in_limit;
    assign w_lim_cmp = CMP_W'(w_lim_sat);
    assign w_occ_cmp = CMP_W'(r_occ);
    always_comb begin
        case (i_in_cmd)
            CMD_LINE: w_lim_new = (w_lim_sat != '0) ? (w_lim_sat - LIM_W'(1)) : '0;
            CMD_PEEK: w_lim_new = (w_lim_cmp > w_occ_cmp) ? LIM_W'(w_occ_cmp) : w_lim_sat;
            default:  w_lim_new = LIM_W'(1);
        endcase
    end

    // Last byte of the current burst
    always_comb begin
        case (r_cmd)
            CMD_LINE: w_done = (r_rdata == NEWLINE) || (w_len_inc >= r_lim)
                               || (r_occ == OCC_W'(1));
            CMD_PEEK: w_done = (w_len_inc == r_lim);
            default:  w_done = 1'b1;
        endcase
    end

    // Status to controller
    assign o_stat.cmd       = r_cmd;
    assign o_stat.occ_zero  = (r_occ == '0);
    assign o_stat.flag      = r_flag;
    assign o_stat.lim_zero  = (r_lim == '0);
    assign o_stat.byte_done = w_done;
    assign o_stat.out_free  = w_out_free;

    // Next values of FIFO state and output register
    always_comb begin
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        n_occ        = r_occ;
        n_flag       = r_flag;
        n_len        = r_len;
        n_peek_ptr   = r_peek_ptr;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_last   = r_out_last;
        n_out_byte   = r_out_byte;
        n_out_bvalid = r_out_bvalid;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_fill   = r_out_fill;
        n_out_flag   = r_out_flag;

        if (i_cmd.load) begin
            n_len      = '0;
            n_peek_ptr = r_rptr;
        end

        if (i_cmd.put) begin
            if (!w_full) begin
                n_wptr = ptr_inc(r_wptr);
                n_occ  = r_occ + OCC_W'(1);
            end
            if (r_data == NEWLINE) begin
                n_flag = 1'b1;
            end
        end

        if (i_cmd.emit_none && i_cmd.clr_flag) begin
            n_flag = 1'b0;
        end

        if (i_cmd.emit_byte) begin
            n_len = w_len_inc;
            if (w_pop) begin
                n_rptr = ptr_inc(r_rptr);
                n_occ  = r_occ - OCC_W'(1);
                if (r_occ == OCC_W'(1)) begin
                    n_flag = 1'b0;
                end
            end else begin
                n_peek_ptr = ptr_inc(r_peek_ptr);
            end
            if ((r_cmd == CMD_LINE) && w_done) begin
                n_flag = 1'b0;
            end
        end

        // Result word
        if (i_cmd.put || i_cmd.emit_none || i_cmd.emit_byte) begin
            n_out_valid  = 1'b1;
            n_out_last   = i_cmd.emit_byte ? w_done : 1'b1;
            n_out_byte   = i_cmd.emit_byte ? r_rdata : '0;
            n_out_bvalid = i_cmd.emit_byte;
            n_out_fill   = FILL_W'(n_occ);
            n_out_flag   = n_flag;
            n_out_len    = (i_cmd.emit_byte && (r_cmd == CMD_LINE)) ? LEN_W'(w_len_inc) : '0;
            if (i_cmd.put) begin
                n_out_status = w_full ? ST_FULL : ST_OK;
            end else if (i_cmd.emit_none) begin
                n_out_status = i_cmd.none_status;
            end else begin
                n_out_status = ST_OK;
            end
        end
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.put && !w_full) begin
            r_mem[r_wptr] <= r_data;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[(r_cmd == CMD_PEEK) ? r_peek_ptr : r_rptr];
        end
    end

    // Latched transaction and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_in_cmd;
            r_data <= i_in_data;
            r_lim  <= w_lim_new;
        end
        r_len        <= n_len;
        r_peek_ptr   <= n_peek_ptr;
        r_out_last   <= n_out_last;
        r_out_byte   <= n_out_byte;
        r_out_bvalid <= n_out_bvalid;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_fill   <= n_out_fill;
        r_out_flag   <= n_out_flag;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_occ       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_occ       <= n_occ;
            r_flag      <= n_flag;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_m_tlast     = r_out_last;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_out_bvalid;
    assign o_status      = r_out_status;
    assign o_line_length = r_out_len;
    assign o_fill_level  = r_out_fill;
    assign o_line_ready  = r_out_flag;

    `BRFLD_ASSERT_NOW(a_occ_range, 1'b1, r_occ <= OCC_W'(DEPTH), "occupancy above depth")
    `BRFLD_ASSERT_NOW(a_flag_occ, r_flag, r_occ != '0, "line flag set on empty FIFO")
    `BRFLD_ASSERT_NOW(a_pop_nonempty, w_pop, r_occ != '0, "pop from empty FIFO")

endmodule

`default_nettype wire

### hdl/byte_ring_fifo_with_line_detect_core.sv
`default_nettype none
// Byte ring FIFO with line detect.
// Slave stream: tuser[1:0] command (put, get, read line, peek); tdata[7:0] byte to
// put, tdata[14:8] limit (line buffer length or peek count, capped at 64).
// Master stream: one transaction per result; tlast marks the final result of a
// command. tuser carries byte_valid and status, tdata the byte, line length,
// fill level and line flag.
// Timing: a command is taken in the idle state, then executed. Put, and every
// command that returns no byte, writes its result to the output register as it
// executes. Commands that return bytes (get, read line, peek) pass through a
// read state and an emit state per byte, set by the registered read port of the
// 256-entry byte store; the slave side stays busy until the last byte of an item
// is emitted: a new command waits for the one before it. One item at a time.
// The slave side is ready whenever no command is in progress, even while a
// finished result waits in the output register. When the master side stalls,
// work stops before the next result and the output register holds its value.
// Reset (synchronous, active low) empties the FIFO, clears the line flag and
// drops any pending result; the store contents are not cleared and need no
// clearing pass, since only occupied entries are ever read.
module byte_ring_fifo_with_line_detect_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // data_byte[7:0], limit[14:8], zero [15]
    input  wire logic [1:0]  i_s_tuser,   // command[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // out_byte[7:0], line_length[13:8],
                                          // fill_level[22:14], line_ready[23]
    output logic [2:0]       o_m_tuser,   // byte_valid[0], status[2:1]
    output logic             o_m_tlast
);
    import brfld_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [BYTE_W-1:0] w_out_byte;
    logic              w_byte_valid;
    logic [STAT_W-1:0] w_status;
    logic [LEN_W-1:0]  w_line_length;
    logic [FILL_W-1:0] w_fill_level;
    logic              w_line_ready;

    brfld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    brfld_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_cmd      (i_s_tuser[CMD_W-1:0]),
        .i_in_data     (i_s_tdata[BYTE_W-1:0]),
        .i_in_limit    (i_s_tdata[BYTE_W+LIM_W-1:BYTE_W]),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_m_tlast     (o_m_tlast),
        .o_out_byte    (w_out_byte),
        .o_byte_valid  (w_byte_valid),
        .o_status      (w_status),
        .o_line_length (w_line_length),
        .o_fill_level  (w_fill_level),
        .o_line_ready  (w_line_ready)
    );

    // Pack result fields, lowest first
    assign o_m_tdata = {w_line_ready, w_fill_level, w_line_length, w_out_byte};
    assign o_m_tuser = {w_status, w_byte_valid};

endmodule

`default_nettype wire

### tb/byte_ring_fifo_with_line_detect_core_tb.sv
`default_nettype none

module byte_ring_fifo_with_line_detect_core_tb;
    import brfld_pkg::*;

    // One result transaction as the block should report it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [1:0] status;
        logic [5:0] line_length;
        logic [8:0] fill_level;
        logic       line_ready;
    } fifo_result_t;

    // Mirror of the byte ring and its line flag; holds the results still owed
    class byte_fifo_mirror;
        logic [7:0]   ring [DEPTH];
        int unsigned  wr_ptr;
        int unsigned  rd_ptr;
        int unsigned  occupancy;
        bit           line_flag;
        fifo_result_t expected_results [$];
        int unsigned  mismatch_count;

        function new();
            wr_ptr         = 0;
            rd_ptr         = 0;
            occupancy      = 0;
            line_flag      = 1'b0;
            mismatch_count = 0;
        endfunction

        // Queue one result carrying the fill level and flag as they stand now
        function void owe(logic [7:0] b, bit valid, bit last, logic [1:0] status,
                          int unsigned len);
            fifo_result_t r;
            r.out_byte    = b;
            r.byte_valid  = valid;
            r.last        = last;
            r.status      = status;
            r.line_length = 6'(len);
            r.fill_level  = 9'(occupancy);
            r.line_ready  = line_flag;
            expected_results.push_back(r);
        endfunction

        function logic [7:0] pop_byte();
            logic [7:0] b;
            b         = ring[rd_ptr];
            rd_ptr    = (rd_ptr + 1) % DEPTH;
            occupancy = occupancy - 1;
            if (occupancy == 0) line_flag = 1'b0;
            return b;
        endfunction

        // Accepted command transaction
        function void take_command(logic [1:0] cmd, logic [7:0] data, logic [6:0] lim_in);
            int unsigned lim;
            int unsigned take;
            int unsigned len;
            int unsigned n;
            logic [7:0]  b;
            logic [1:0]  st;
            bit          done;
            lim = (lim_in > MAX_BURST) ? MAX_BURST : lim_in;
            case (cmd)
                CMD_PUT: begin
                    st = ST_OK;
                    if (occupancy < DEPTH) begin
                        ring[wr_ptr] = data;
                        wr_ptr       = (wr_ptr + 1) % DEPTH;
                        occupancy    = occupancy + 1;
                    end else begin
                        st = ST_FULL;
                    end
                    // a newline raises the flag even when dropped
                    if (data == NEWLINE) line_flag = 1'b1;
                    owe(8'h00, 1'b0, 1'b1, st, 0);
                end
                CMD_GET: begin
                    if (occupancy == 0) begin
                        owe(8'h00, 1'b0, 1'b1, ST_EMPTY, 0);
                    end else begin
                        b = pop_byte();
                        owe(b, 1'b1, 1'b1, ST_OK, 0);
                    end
                end
                CMD_LINE: begin
                    take = (lim > 0) ? lim - 1 : 0;
                    if (!line_flag) begin
                        owe(8'h00, 1'b0, 1'b1, ST_EMPTY, 0);
                    end else if (take == 0 || occupancy == 0) begin
                        line_flag = 1'b0;
                        owe(8'h00, 1'b0, 1'b1, ST_OK, 0);
                    end else begin
                        // length checked after each pop
                        len  = 0;
                        done = 1'b0;
                        while (!done) begin
                            b    = pop_byte();
                            len  = len + 1;
                            done = (b == NEWLINE) || (len >= take) || (occupancy == 0);
                            if (done) line_flag = 1'b0;
                            owe(b, 1'b1, done, ST_OK, len);
                        end
                    end
                end
                default: begin
                    // peek leaves the ring untouched
                    if (occupancy == 0) begin
                        owe(8'h00, 1'b0, 1'b1, ST_EMPTY, 0);
                    end else begin
                        n = (lim > occupancy) ? occupancy : lim;
                        if (n == 0) begin
                            owe(8'h00, 1'b0, 1'b1, ST_OK, 0);
                        end else begin
                            for (int unsigned i = 0; i < n; i++) begin
                                owe(ring[(rd_ptr + i) % DEPTH], 1'b1, i == n - 1, ST_OK, 0);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        endfunction

        // Accepted result transaction against the oldest one owed
        function void match_result(logic [23:0] tdata, logic [2:0] tuser, logic tlast);
            fifo_result_t want;
            if (expected_results.size() == 0) begin
                $error("result with none expected: tdata %h tuser %h tlast %b",
                       tdata, tuser, tlast);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            check_field("out_byte", 9'(want.out_byte), 9'(tdata[7:0]));
            check_field("byte_valid", 9'(want.byte_valid), 9'(tuser[0]));
            check_field("last", 9'(want.last), 9'(tlast));
            check_field("status", 9'(want.status), 9'(tuser[2:1]));
            check_field("line_length", 9'(want.line_length), 9'(tdata[13:8]));
            check_field("fill_level", want.fill_level, tdata[22:14]);
            check_field("line_ready", 9'(want.line_ready), 9'(tdata[23]));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // data_byte[7:0], limit[14:8], zero [15]
    logic [1:0]  i_s_tuser;   // command[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // out_byte[7:0], line_length[13:8], fill_level[22:14],
                              // line_ready[23]
    logic [2:0]  o_m_tuser;   // byte_valid[0], status[2:1]
    logic        o_m_tlast;

    byte_fifo_mirror tracker = new();
    bit              bursty = 1'b1;
    int              items_sent = 0;

    byte_ring_fifo_with_line_detect_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("byte_ring_fifo_with_line_detect_core_tb: done, errors");
        $finish;
    end

    // Both transaction kinds sampled at the edge; commands noted before results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.take_command(i_s_tuser, i_s_tdata[7:0], i_s_tdata[14:8]);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.match_result(o_m_tdata, o_m_tuser, o_m_tlast);
            end
        end
    end

    // Result sink with random stall bursts
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (bursty && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] data,
                                input logic [6:0] lim);
        if (bursty && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, lim, data};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NEWLINE) b = 8'h0B;
        return b;
    endfunction

    // Read line length: mostly ordinary, now and then tiny or over the cap
    function automatic logic [6:0] line_limit();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 7'($urandom_range(0, 2));
        if (pick == 1) return 7'($urandom_range(65, 127));
        return 7'($urandom_range(3, 64));
    endfunction

    task automatic put_line(input int unsigned len);
        repeat (len - 1) send_command(CMD_PUT, plain_byte(), 7'($urandom_range(0, 127)));
        send_command(CMD_PUT, NEWLINE, 7'($urandom_range(0, 127)));
    endtask

    initial begin
        bit filled;
        filled = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_PUT;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty cases, field extremes, flag handling, all stop reasons
        send_command(CMD_GET, 8'h00, 7'd1);
        send_command(CMD_PEEK, 8'hFF, 7'd5);
        send_command(CMD_LINE, 8'h00, 7'd64);
        send_command(CMD_PUT, 8'h00, 7'd0);
        send_command(CMD_PUT, 8'hFF, 7'd127);
        send_command(CMD_PUT, 8'h41, 7'd1);
        send_command(CMD_LINE, 8'hFF, 7'd64);    // bytes held, no newline yet
        send_command(CMD_PUT, NEWLINE, 7'd64);
        send_command(CMD_PUT, 8'h55, 7'd64);
        send_command(CMD_PEEK, 8'h00, 7'd0);     // zero count, not empty
        send_command(CMD_PEEK, 8'h00, 7'd127);   // count saturates, then capped by fill
        send_command(CMD_PEEK, 8'h00, 7'd2);
        send_command(CMD_LINE, 8'h00, 7'd1);     // takes nothing, still drops flag
        send_command(CMD_LINE, 8'h00, 7'd64);    // flag gone
        send_command(CMD_PUT, NEWLINE, 7'd0);
        send_command(CMD_LINE, 8'h00, 7'd0);     // zero length
        send_command(CMD_PUT, NEWLINE, 7'd0);
        send_command(CMD_LINE, 8'h00, 7'd3);     // stops on length
        send_command(CMD_PUT, NEWLINE, 7'd0);
        send_command(CMD_LINE, 8'h00, 7'd100);   // stops after newline
        repeat (5) send_command(CMD_GET, 8'h00, 7'd0);  // drain, last get finds the ring empty
        send_command(CMD_PUT, NEWLINE, 7'd9);
        send_command(CMD_PUT, 8'h62, 7'd9);
        send_command(CMD_GET, 8'h00, 7'd9);      // newline gone, flag stays
        send_command(CMD_LINE, 8'h00, 7'd64);    // runs the ring empty

        // Random: mostly well-formed lines, some noise, one pass through full
        while (items_sent < 470) begin
            if (items_sent > 400) bursty = 1'b0;
            if (!filled && items_sent > 100) begin
                filled = 1'b1;
                // overfill; one of the dropped bytes is a newline
                for (int i = 0; i < DEPTH + 8; i++) begin
                    if (i == DEPTH + 4 || $urandom_range(0, 39) == 0) begin
                        send_command(CMD_PUT, NEWLINE, 7'($urandom_range(0, 127)));
                    end else begin
                        send_command(CMD_PUT, plain_byte(), 7'($urandom_range(0, 127)));
                    end
                end
                send_command(CMD_PEEK, 8'h00, 7'd64);
                // bounded: a ring of lone newlines would never shrink
                for (int k = 0; k < 16 && tracker.occupancy > 8; k++) begin
                    send_command(CMD_PUT, NEWLINE, 7'd0);
                    send_command(CMD_LINE, 8'h00, 7'd64);
                end
            end else if ($urandom_range(0, 9) < 7) begin
                repeat ($urandom_range(1, 2)) put_line($urandom_range(1, 24));
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_command(CMD_PUT, plain_byte(), 7'($urandom_range(0, 127)));
                    end
                end
                send_command(CMD_LINE, 8'($urandom_range(0, 255)), line_limit());
                if ($urandom_range(0, 1) == 0) begin
                    send_command(CMD_PEEK, 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 80)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_command(CMD_LINE, 8'($urandom_range(0, 255)), line_limit());
                end
                if (tracker.occupancy > 96) begin
                    repeat ($urandom_range(4, 16)) begin
                        send_command(CMD_GET, 8'($urandom_range(0, 255)),
                                     7'($urandom_range(0, 127)));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                 7'($urandom_range(0, 127)));
                end
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.mismatch_count == 0) begin
            $display("byte_ring_fifo_with_line_detect_core_tb: done, clean");
        end else begin
            $display("byte_ring_fifo_with_line_detect_core_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
